// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Field widths, command and status codes, and the control word that the
// top level broadcasts down the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // field widths of the input and result words
  localparam int CMD_W   = 2;
  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // entries per group of the read-out tree
  localparam int GATHER_GROUP = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // what every cell does in one shift cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REM
  } ple_op_t;

  typedef struct packed {
    ple_op_t            op;
    logic [POS_W-1:0]   slot;
  } ple_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ple_if.sv =====
// ----------------------------------------------------------------------------
// ple_if: channel interfaces of the positional list engine
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_in_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [POS_W-1:0]   position;
  logic [WORD_W-1:0]  word_in;

  modport source (output valid, output cmd, output position, output word_in, input ready);
  modport sink   (input valid, input cmd, input position, input word_in, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  word_out;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output word_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input word_out, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list with positional insert/remove
// Top level: command decode, fill count, result register and the cell row.
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries one command word: cmd (insert, remove, read), a 1-based
//   position and the data word for an insert. out_ch returns one result word
//   per command: the removed or read data, a status code and the entry count
//   after the command. Both channels move a word when valid and ready are high.
//   A command passes the shift cycle of the cell row, which also captures
//   the read-out, then the result load, which waits for a free output register;
//   the next command is taken only once that result is loaded. The row shifts
//   all entries at once, so the cost does not depend on position or list length.
//   A new command is taken while the previous result still waits in the
//   output register; a stalled receiver holds the block before the result
//   stage until that register frees up.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; the entries need no clearing since only filled ones are read.
//   Out-of-range positions, empty-list accesses and unknown commands give
//   status bad position; an insert into a full list gives status full;
//   neither changes the list.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);
  import ple_pkg::*;

  localparam int SW    = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COLLECT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  ple_ctrl_t            ctrl_r;
  logic [SW-1:0]        word_r;
  logic [STAT_W-1:0]    status_r;
  logic                 take_r;
  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_word_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [COUNT_W-1:0]   out_count_r;

  ple_ctrl_t            dec_ctrl;
  logic [STAT_W-1:0]    dec_status;
  logic                 dec_take;
  logic                 in_fire;
  ple_ctrl_t            cell_ctrl;
  logic [SW-1:0]        cell_q [CAPACITY];
  logic [SW-1:0]        gather_word;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // command check against the current fill count
  always_comb begin
    dec_ctrl.op   = OP_HOLD;
    dec_ctrl.slot = in_ch.position - POS_W'(1);
    dec_status    = ST_BADPOS;
    dec_take      = 1'b0;
    if (in_ch.position != '0) begin
      unique case (in_ch.cmd)
        CMD_INSERT: begin
          if (int'(in_ch.position) <= int'(cnt_r) + 1) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              dec_status = ST_FULL;
            end else begin
              dec_ctrl.op = OP_INS;
              dec_status  = ST_DONE;
            end
          end
        end
        CMD_REMOVE: begin
          if (int'(in_ch.position) <= int'(cnt_r)) begin
            dec_ctrl.op = OP_REM;
            dec_status  = ST_DONE;
            dec_take    = 1'b1;
          end
        end
        CMD_READ: begin
          if (int'(in_ch.position) <= int'(cnt_r)) begin
            dec_status = ST_DONE;
            dec_take   = 1'b1;
          end
        end
        default: begin
          dec_status = ST_BADPOS;
        end
      endcase
    end
  end

  // control word seen by the cells: active only in the shift cycle
  always_comb begin
    cell_ctrl = ctrl_r;
    if (state_r != S_EXEC) begin
      cell_ctrl.op = OP_HOLD;
    end
  end

  // row of list cells, each talking to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] left_d;
    logic [SW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = word_r;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    ple_cell #(
      .W   (SW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .word_in (word_r),
      .left_q  (left_d),
      .right_q (right_d),
      .q       (cell_q[i])
    );
  end

  // read-out of the addressed entry, captured before the row shifts
  ple_gather #(
    .N (CAPACITY),
    .W (SW)
  ) u_gather (
    .clk     (clk),
    .capture (state_r == S_EXEC),
    .slot    (ctrl_r.slot),
    .entries (cell_q),
    .result  (gather_word)
  );

  // sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ctrl_r.op   <= OP_HOLD;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken while no new one is loaded
      if (out_valid_r && out_ch.ready && state_r != S_COLLECT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ctrl_r   <= dec_ctrl;
            word_r   <= in_ch.word_in[SW-1:0];
            status_r <= dec_status;
            take_r   <= dec_take;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ctrl_r.op == OP_INS) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else if (ctrl_r.op == OP_REM) begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
          state_r <= S_COLLECT;
        end
        S_COLLECT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_word_r   <= take_r ? WORD_W'(gather_word) : '0;
            out_status_r <= status_r;
            out_count_r  <= COUNT_W'(cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.word_out    = out_word_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

`ifndef SYNTHESIS
  // fill count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= CAPACITY)
    else $error("fill count beyond capacity");

  // the list length moves only in the shift cycle
  a_count_moves_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(state_r) == S_EXEC))
    else $error("fill count changed outside the shift cycle");

  // a full status is only given for a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && status_r == ST_FULL) |-> (cnt_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // failed commands return no data
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DONE) |-> (out_word_r == '0))
    else $error("data returned with an error status");
`endif

endmodule

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one entry of the list
// Holds one data word; on a shift cycle it takes its left neighbor, its right
// neighbor or the new word, depending on its place relative to the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int W   = 32,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire ple_pkg::ple_ctrl_t ctrl,
  input  wire logic [W-1:0]      word_in,
  input  wire logic [W-1:0]      left_q,
  input  wire logic [W-1:0]      right_q,
  output      logic [W-1:0]      q
);
  import ple_pkg::*;

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  // pick the new content from the neighbors or the inserted word
  always_comb begin
    q_nxt = q_r;
    unique case (ctrl.op)
      OP_HOLD: q_nxt = q_r;
      OP_INS: begin
        if (IDX > int'(ctrl.slot)) begin
          q_nxt = left_q;
        end else if (IDX == int'(ctrl.slot)) begin
          q_nxt = word_in;
        end
      end
      OP_REM: begin
        if (IDX >= int'(ctrl.slot)) begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/ple_gather.sv =====
// ----------------------------------------------------------------------------
// ple_gather: read-out tree over the cell row
// First level selects the addressed entry inside groups of cells into
// registers; second level merges the group registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_gather #(
  parameter int N = 32,
  parameter int W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     capture,
  input  wire logic [ple_pkg::POS_W-1:0] slot,
  input  wire logic [W-1:0]             entries [N],
  output      logic [W-1:0]             result
);
  import ple_pkg::*;

  localparam int NG = (N + GATHER_GROUP - 1) / GATHER_GROUP;

  logic [W-1:0] grp_r   [NG];
  logic [W-1:0] grp_nxt [NG];

  // first level: and-or select within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
    end
    for (int k = 0; k < N; k++) begin
      if (k == int'(slot)) begin
        grp_nxt[k / GATHER_GROUP] = grp_nxt[k / GATHER_GROUP] | entries[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // second level: merge the groups, only one can be nonzero
  always_comb begin
    result = '0;
    for (int g = 0; g < NG; g++) begin
      result = result | grp_r[g];
    end
  end

endmodule

`default_nettype wire
